>>> rtl/ljpf_pkg.sv
`default_nettype none
package ljpf_pkg;

   localparam int unsigned POS_W   = 24;
   localparam int unsigned DIFF_W  = POS_W + 2;
   localparam int unsigned SQ_W    = 2 * POS_W;
   localparam int unsigned R2_W    = SQ_W + 2;
   localparam int unsigned VAL_W   = 62;
   localparam int unsigned OUT_W   = 40;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned IDX_W   = 2;
   localparam int unsigned MUL_LAT = 3;

   localparam logic [VAL_W-1:0] CAP     = 62'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] POS_MAG = 62'h7F_FFFF_FFFF;
   localparam logic [VAL_W-1:0] NEG_MAG = 62'h80_0000_0000;

   localparam logic [23:0] BOX_RST   = 24'd6553600;
   localparam logic [31:0] CUTSQ_RST = 32'd12210995;
   localparam logic [23:0] DEPTH_RST = 24'd6554;
   localparam logic [31:0] SIG6_RST  = 32'd230604391;

   typedef enum logic [IDX_W-1:0] {
      CSR_BOX    = 2'd0,
      CSR_CUTSQ  = 2'd1,
      CSR_DEPTH  = 2'd2,
      CSR_SIGMA6 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0][OUT_W-1:0] frc;
      logic [OUT_W-1:0]      energy;
      logic                  live;
   } res_type;

   typedef struct packed {
      logic                   valid;
      logic                   same;
      logic [2:0][DIFF_W-1:0] d;
      logic [2:0][POS_W-1:0]  mag;
      logic [2:0]             neg;
      logic [2:0]             zero;
      logic [2:0][SQ_W-1:0]   sq;
      logic [R2_W-1:0]        r2;
      logic                   live;
      logic                   tiny;
      logic [R2_W-1:0]        rem;
      logic [VAL_W-1:0]       quo;
      logic [VAL_W-1:0]       rinv2;
      logic [VAL_W-1:0]       t6;
      logic                   eneg;
      logic [VAL_W-1:0]       ediff;
      logic                   coreneg;
      logic [VAL_W:0]         core;
      logic                   ovf;
      logic [VAL_W-1:0]       emag;
      res_type                res;
   } pipe_type;

   // clamp a magnitude into a signed 40-bit result
   function automatic logic [OUT_W-1:0] to_out(input logic [VAL_W-1:0] mag, input logic neg);
      logic [VAL_W-1:0] m;
      logic [VAL_W-1:0] n;
      if (neg) begin
         m = (mag > NEG_MAG) ? NEG_MAG : mag;
         n = '0 - m;
         return n[OUT_W-1:0];
      end
      m = (mag > POS_MAG) ? POS_MAG : mag;
      return m[OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/ljpf_if.sv
`default_nettype none
interface ljpf_req_if;
   logic                          valid;
   logic                          ready;
   logic [ljpf_pkg::POS_W-1:0]    first_x;
   logic [ljpf_pkg::POS_W-1:0]    first_y;
   logic [ljpf_pkg::POS_W-1:0]    first_z;
   logic [ljpf_pkg::POS_W-1:0]    second_x;
   logic [ljpf_pkg::POS_W-1:0]    second_y;
   logic [ljpf_pkg::POS_W-1:0]    second_z;
   logic                          same_molecule;
   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   same_molecule, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 same_molecule, output ready);
endinterface

interface ljpf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ljpf_pkg::OUT_W-1:0]  force_x;
   logic signed [ljpf_pkg::OUT_W-1:0]  force_y;
   logic signed [ljpf_pkg::OUT_W-1:0]  force_z;
   logic signed [ljpf_pkg::OUT_W-1:0]  pair_energy;
   logic                               interacting;
   modport source (output valid, force_x, force_y, force_z, pair_energy, interacting,
                   input ready);
   modport sink (input valid, force_x, force_y, force_z, pair_energy, interacting,
                 output ready);
endinterface

interface ljpf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ljpf_pkg::IDX_W-1:0]    index;
   logic [ljpf_pkg::CSR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/ljpf_mul.sv
`default_nettype none
// 64x64 multiply, shift right, cap; three register stages built from 32x32 products
module ljpf_mul #(
   parameter int unsigned SHIFT = 32
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [63:0]                a,
   input  wire logic [63:0]                b,
   output logic [ljpf_pkg::VAL_W-1:0]      q,
   output logic                            sat
);
   import ljpf_pkg::*;

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [96:0]  lo_ff, hi_ff;
   logic [127:0] prod;
   logic [127:0] shifted;
   logic         over;

   always_comb begin
      prod    = {31'b0, lo_ff} + {hi_ff[95:0], 32'b0};
      shifted = prod >> SHIFT;
      over    = |shifted[127:VAL_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[31:0] * b[31:0];
         lh_ff <= a[31:0] * b[63:32];
         hl_ff <= a[63:32] * b[31:0];
         hh_ff <= a[63:32] * b[63:32];
         lo_ff <= {33'b0, ll_ff} + {1'b0, lh_ff, 32'b0};
         hi_ff <= {33'b0, hl_ff} + {1'b0, hh_ff, 32'b0};
         q     <= over ? CAP : shifted[VAL_W-1:0];
         sat   <= over;
      end
   end
endmodule
`default_nettype wire

>>> rtl/lj_pair_force_kernel.sv
// Lennard-Jones 12-6 pair force with minimum-image boundaries, one atom pair per cycle
// while the output skid stage is empty. A 62-stage restoring divider forms 1/r^2;
// ten 3-stage multipliers follow it.
// Throughput: one pair per cycle; a full output skid stage holds the pipe until rsp transfers.
// Reset (synchronous, active high): drop every item in flight, load register defaults.
`default_nettype none
module lj_pair_force_kernel (
   input wire logic   clock,
   input wire logic   reset,
   ljpf_req_if.sink   req_bus,
   ljpf_rsp_if.source rsp_bus,
   ljpf_csr_if.sink   csr_bus
);
   import ljpf_pkg::*;

   // stage map: the pipe register index at which each quantity is ready
   localparam int unsigned DIV_FIRST = 6;
   localparam int unsigned ST_RINV   = DIV_FIRST + VAL_W;
   localparam int unsigned ST_R4     = ST_RINV + MUL_LAT;
   localparam int unsigned ST_R6     = ST_R4 + MUL_LAT;
   localparam int unsigned ST_T6     = ST_R6 + MUL_LAT;
   localparam int unsigned ST_T12    = ST_T6 + MUL_LAT;
   localparam int unsigned ST_CORE   = ST_T12 + 1;
   localparam int unsigned ST_PROD   = ST_CORE + MUL_LAT;
   localparam int unsigned ST_H      = ST_PROD + MUL_LAT;
   localparam int unsigned ST_F      = ST_H + MUL_LAT;
   localparam int unsigned ST_OUT    = ST_F + 1;
   localparam int unsigned NSTG      = ST_OUT + 1;

   // configuration registers
   logic [23:0] box_ff;
   logic [31:0] cut_ff;
   logic [23:0] wd_ff;
   logic [28:0] wd24_ff;
   logic [31:0] s6_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff  <= BOX_RST;
         cut_ff  <= CUTSQ_RST;
         wd_ff   <= DEPTH_RST;
         wd24_ff <= {1'b0, DEPTH_RST, 4'b0} + {2'b0, DEPTH_RST, 3'b0};
         s6_ff   <= SIG6_RST;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_BOX:    box_ff <= csr_bus.data[23:0];
            CSR_CUTSQ:  cut_ff <= csr_bus.data;
            CSR_DEPTH: begin
               wd_ff   <= csr_bus.data[23:0];
               // keep 24*epsilon alongside so the force multiply needs no pre-add
               wd24_ff <= {1'b0, csr_bus.data[23:0], 4'b0} + {2'b0, csr_bus.data[23:0], 3'b0};
            end
            CSR_SIGMA6: s6_ff  <= csr_bus.data;
            default:    box_ff <= box_ff;
         endcase
      end
   end

   // main pipe: every stage advances together while the skid stage is empty
   pipe_type pipe_ff [NSTG];
   pipe_type pipe_in [NSTG];
   logic     en;

   res_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;

   logic [VAL_W-1:0] m1_q, m2_q, m3_q, m4_q, m5a_q, m5b_q, m6_q;
   logic [VAL_W-1:0] m7_q [3];
   logic             m4_sat;

   assign en            = !skid_valid_ff;
   assign req_bus.ready = en;

   always_comb begin
      logic [DIFF_W-1:0] dneg;
      logic [R2_W:0]     sh;
      logic              ge;
      logic [VAL_W-1:0]  t12;
      logic [VAL_W-1:0]  t6;
      logic [VAL_W:0]    t12x2;
      logic [VAL_W:0]    t6w;
      pipe_type          p;

      // stage 0: raw differences
      pipe_in[0]       = '0;
      pipe_in[0].valid = req_bus.valid;
      pipe_in[0].same  = req_bus.same_molecule;
      pipe_in[0].d[0]  = {2'b0, req_bus.first_x} - {2'b0, req_bus.second_x};
      pipe_in[0].d[1]  = {2'b0, req_bus.first_y} - {2'b0, req_bus.second_y};
      pipe_in[0].d[2]  = {2'b0, req_bus.first_z} - {2'b0, req_bus.second_z};

      for (int k = 1; k < NSTG; k++) pipe_in[k] = pipe_ff[k-1];

      for (int a = 0; a < 3; a++) begin
         // minimum image: pull down by one box when past half a box
         if ($signed({pipe_ff[0].d[a], 1'b0}) > $signed({3'b0, box_ff}))
            pipe_in[1].d[a] = pipe_ff[0].d[a] - {2'b0, box_ff};
         // then push up by one box when at or below minus half a box
         if ($signed({pipe_ff[1].d[a], 1'b0}) <= -$signed({3'b0, box_ff}))
            pipe_in[2].d[a] = pipe_ff[1].d[a] + {2'b0, box_ff};
         // magnitude, sign and square
         dneg               = '0 - pipe_ff[2].d[a];
         pipe_in[3].neg[a]  = pipe_ff[2].d[a][DIFF_W-1];
         pipe_in[3].zero[a] = (pipe_ff[2].d[a] == '0);
         pipe_in[3].mag[a]  = pipe_ff[2].d[a][DIFF_W-1] ? dneg[POS_W-1:0]
                                                       : pipe_ff[2].d[a][POS_W-1:0];
         pipe_in[3].sq[a]   = pipe_in[3].mag[a] * pipe_in[3].mag[a];
      end

      pipe_in[4].r2 = {2'b0, pipe_ff[3].sq[0]} + {2'b0, pipe_ff[3].sq[1]}
                    + {2'b0, pipe_ff[3].sq[2]};

      // exclusion and cutoff; seed the divider for 2^64 / r2 (top three quotient bits are zero)
      pipe_in[5].live = !pipe_ff[4].same && (pipe_ff[4].r2 < {2'b0, cut_ff, 16'b0});
      pipe_in[5].tiny = (pipe_ff[4].r2 <= R2_W'(4));
      pipe_in[5].rem  = R2_W'(4);
      pipe_in[5].quo  = '0;

      // one quotient bit per stage
      for (int j = 0; j < VAL_W; j++) begin
         sh = {pipe_ff[DIV_FIRST+j-1].rem, 1'b0};
         ge = (sh >= {1'b0, pipe_ff[DIV_FIRST+j-1].r2});
         pipe_in[DIV_FIRST+j].rem = ge ? R2_W'(sh - {1'b0, pipe_ff[DIV_FIRST+j-1].r2})
                                       : sh[R2_W-1:0];
         pipe_in[DIV_FIRST+j].quo = {pipe_ff[DIV_FIRST+j-1].quo[VAL_W-2:0], ge};
      end

      pipe_in[ST_RINV].rinv2 = pipe_ff[ST_RINV-1].tiny ? CAP : pipe_ff[ST_RINV-1].quo;
      pipe_in[ST_T6+1].t6    = m3_q;

      // energy and force cores from t6 and t12
      t12   = m4_q;
      t6    = pipe_ff[ST_T12].t6;
      t12x2 = {t12, 1'b0};
      t6w   = {1'b0, t6};
      pipe_in[ST_CORE].eneg    = (t12 < t6);
      pipe_in[ST_CORE].ediff   = (t12 < t6) ? t6 - t12 : t12 - t6;
      pipe_in[ST_CORE].coreneg = (t12x2 < t6w);
      pipe_in[ST_CORE].core    = (t12x2 < t6w) ? t6w - t12x2 : t12x2 - t6w;
      pipe_in[ST_CORE].ovf     = m4_sat && (wd_ff != '0);

      pipe_in[ST_PROD+1].emag = m5a_q;

      // result formatting
      p = pipe_ff[ST_F];
      pipe_in[ST_OUT].res = '0;
      if (p.live) begin
         pipe_in[ST_OUT].res.live = 1'b1;
         if (p.ovf) begin
            // repulsion overflow: largest values with the sign of each offset
            pipe_in[ST_OUT].res.energy = to_out(POS_MAG, 1'b0);
            for (int a = 0; a < 3; a++)
               pipe_in[ST_OUT].res.frc[a] = p.zero[a] ? '0 : to_out(NEG_MAG, p.neg[a]);
         end else begin
            pipe_in[ST_OUT].res.energy = to_out(p.emag, p.eneg);
            for (int a = 0; a < 3; a++)
               pipe_in[ST_OUT].res.frc[a] = to_out(m7_q[a], p.coreneg != p.neg[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) pipe_ff[k].valid <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < NSTG; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

   // multiplier chain
   ljpf_mul #(.SHIFT(32)) u_mul_r4 (
      .clock(clock), .en(en),
      .a({2'b0, pipe_ff[ST_RINV].rinv2}), .b({2'b0, pipe_ff[ST_RINV].rinv2}),
      .q(m1_q), .sat());

   ljpf_mul #(.SHIFT(32)) u_mul_r6 (
      .clock(clock), .en(en),
      .a({2'b0, m1_q}), .b({2'b0, pipe_ff[ST_R4].rinv2}),
      .q(m2_q), .sat());

   ljpf_mul #(.SHIFT(16)) u_mul_t6 (
      .clock(clock), .en(en),
      .a({32'b0, s6_ff}), .b({2'b0, m2_q}),
      .q(m3_q), .sat());

   ljpf_mul #(.SHIFT(32)) u_mul_t12 (
      .clock(clock), .en(en),
      .a({2'b0, m3_q}), .b({2'b0, m3_q}),
      .q(m4_q), .sat(m4_sat));

   ljpf_mul #(.SHIFT(30)) u_mul_energy (
      .clock(clock), .en(en),
      .a({40'b0, wd_ff}), .b({2'b0, pipe_ff[ST_CORE].ediff}),
      .q(m5a_q), .sat());

   ljpf_mul #(.SHIFT(16)) u_mul_g (
      .clock(clock), .en(en),
      .a({35'b0, wd24_ff}), .b({1'b0, pipe_ff[ST_CORE].core}),
      .q(m5b_q), .sat());

   ljpf_mul #(.SHIFT(32)) u_mul_h (
      .clock(clock), .en(en),
      .a({2'b0, m5b_q}), .b({2'b0, pipe_ff[ST_PROD].rinv2}),
      .q(m6_q), .sat());

   for (genvar a = 0; a < 3; a++) begin : g_axis
      ljpf_mul #(.SHIFT(32)) u_mul_f (
         .clock(clock), .en(en),
         .a({2'b0, m6_q}), .b({40'b0, pipe_ff[ST_H].mag[a]}),
         .q(m7_q[a]), .sat());
   end

   // output register plus skid: the pipe keeps moving while one result waits
   logic take;
   assign take = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en && pipe_ff[ST_OUT].valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && pipe_ff[ST_OUT].valid) begin
         if (!out_valid_ff || take) out_ff <= pipe_ff[ST_OUT].res;
         else                       skid_ff <= pipe_ff[ST_OUT].res;
      end else if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.force_x     = out_ff.frc[0];
   assign rsp_bus.force_y     = out_ff.frc[1];
   assign rsp_bus.force_z     = out_ff.frc[2];
   assign rsp_bus.pair_energy = out_ff.energy;
   assign rsp_bus.interacting = out_ff.live;

endmodule
`default_nettype wire

>>> rtl/ljpf_chk.sv
`default_nettype none
module ljpf_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [39:0] rsp_force_x,
   input wire logic [39:0] rsp_force_y,
   input wire logic [39:0] rsp_force_z,
   input wire logic [39:0] rsp_pair_energy,
   input wire logic        rsp_interacting
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x) && $stable(rsp_force_y)
         && $stable(rsp_force_z) && $stable(rsp_pair_energy) && $stable(rsp_interacting))
      else $error("rsp payload changed under stall");

   // excluded or out-of-cutoff pairs give all-zero results
   a_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_interacting |-> rsp_force_x == '0 && rsp_force_y == '0
         && rsp_force_z == '0 && rsp_pair_energy == '0)
      else $error("nonzero result for a non-interacting pair");

   // a draining output empties the skid stage, so input opens on the next cycle
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |=> req_ready)
      else $error("input held closed while output drained");

   // reset drops every result
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind lj_pair_force_kernel ljpf_chk u_ljpf_chk (
   .clock(clock),
   .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_force_x(rsp_bus.force_x),
   .rsp_force_y(rsp_bus.force_y),
   .rsp_force_z(rsp_bus.force_z),
   .rsp_pair_energy(rsp_bus.pair_energy),
   .rsp_interacting(rsp_bus.interacting)
);
`default_nettype wire
